// ===== hdl/elp_pkg.sv =====
// Shared types, codes and constants for the elevator position loop.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package elp_pkg;

  // Field and datapath widths
  localparam int ACC_W    = 40;   // height accumulator, Q16 cm
  localparam int CNT_W    = 32;   // raw encoder count
  localparam int AMT_W    = 17;   // target or delta, Q8 cm
  localparam int DRV_W    = 16;   // motor command, Q15
  localparam int HGT_W    = 24;   // reported height, Q8 cm
  localparam int ERR_W    = 23;   // clamped error, Q16 cm
  localparam int MA_W     = 33;   // shared multiplier operand A
  localparam int MB_W     = 29;   // shared multiplier operand B
  localparam int PROD_W   = MA_W + MB_W;
  localparam int X_W      = 27;   // rounded speed magnitude before division
  localparam int Q_W      = 17;   // quotient of the division by 700
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Control constants
  localparam logic signed [ERR_W-1:0] ERR_CLAMP   = 23'sd2293760;  // 35 cm in Q16
  localparam logic        [DRV_W-1:0] DRIVE_LIMIT = 16'd19661;     // 0.6 in Q15
  localparam logic        [27:0]      RECIP_700   = 28'd196341362; // floor(2^37 / 700)
  localparam int                      RECIP_SHIFT = 37;
  localparam logic        [10:0]      DIV_700     = 11'd700;
  localparam logic        [27:0]      ROUND_700   = 28'd350;

  // Register reset values
  localparam logic [15:0] LOW_LIMIT_RST    = 16'd0;
  localparam logic [15:0] HIGH_LIMIT_RST   = 16'd25600;
  localparam logic [11:0] TOLERANCE_RST    = 12'd256;
  localparam logic [7:0]  MAX_SPEED_RST    = 8'd70;
  localparam logic [15:0] CM_PER_COUNT_RST = 16'd1964;
  localparam logic [11:0] FAST_FACTOR_RST  = 12'd512;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT    = 3'd0,
    REG_HIGH_LIMIT   = 3'd1,
    REG_TOLERANCE    = 3'd2,
    REG_MAX_SPEED    = 3'd3,
    REG_CM_PER_COUNT = 3'd4,
    REG_FAST_FACTOR  = 3'd5
  } cfg_idx_t;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_MOVE = 2'd2
  } action_t;

  // Configuration register contents
  typedef struct packed {
    logic [15:0] low_limit;
    logic [15:0] high_limit;
    logic [11:0] tolerance;
    logic [7:0]  max_speed;
    logic [15:0] cm_per_count;
    logic [11:0] fast_factor;
  } cfg_t;

  // Operand selection for the shared multiplier
  typedef enum logic [2:0] {
    MUL_TICK,   // count delta times cm_per_count
    MUL_SPEED,  // error times max_speed
    MUL_RECIP,  // magnitude times reciprocal of 700
    MUL_CORR,   // trial quotient times 700
    MUL_FAST    // amount times fast_factor
  } mul_sel_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_MUL,
    ST_TICK_ACC,
    ST_ERR,
    ST_SPEED_MUL,
    ST_SPEED_ABS,
    ST_RECIP_MUL,
    ST_CORR_MUL,
    ST_DRIVE,
    ST_FAST_MUL,
    ST_TARGET,
    ST_DONE
  } state_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_acc;
    logic     ld_err;
    logic     ld_abs;
    logic     ld_q0;
    logic     ld_drive;
    logic     ld_target;
    logic     ld_out;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/elp_if.sv =====
// Request and result channel interfaces of the elevator position loop.
// Depends on elp_pkg for field widths.
`default_nettype none

interface elp_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic signed [elp_pkg::CNT_W-1:0] encoder_count;
  logic                             top_switch;
  logic                             stop_button;
  logic signed [elp_pkg::AMT_W-1:0] amount;
  logic                             fast_move;

  modport source (output valid, action, encoder_count, top_switch, stop_button, amount,
                  fast_move, input ready);
  modport sink   (input valid, action, encoder_count, top_switch, stop_button, amount,
                  fast_move, output ready);
endinterface

interface elp_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [elp_pkg::DRV_W-1:0] drive;
  logic signed [elp_pkg::HGT_W-1:0] height;
  logic                             on_target;

  modport source (output valid, drive, height, on_target, input ready);
  modport sink   (input valid, drive, height, on_target, output ready);
endinterface

`default_nettype wire

// ===== hdl/elp_cfg_regs.sv =====
// Configuration register file of the elevator position loop.
// Depends on elp_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module elp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [elp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [elp_pkg::CFG_DATA_W-1:0] cfg_data,
  output elp_pkg::cfg_t                       cfg
);

  elp_pkg::cfg_t cfg_r;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit    <= elp_pkg::LOW_LIMIT_RST;
      cfg_r.high_limit   <= elp_pkg::HIGH_LIMIT_RST;
      cfg_r.tolerance    <= elp_pkg::TOLERANCE_RST;
      cfg_r.max_speed    <= elp_pkg::MAX_SPEED_RST;
      cfg_r.cm_per_count <= elp_pkg::CM_PER_COUNT_RST;
      cfg_r.fast_factor  <= elp_pkg::FAST_FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        elp_pkg::REG_LOW_LIMIT:    cfg_r.low_limit    <= cfg_data;
        elp_pkg::REG_HIGH_LIMIT:   cfg_r.high_limit   <= cfg_data;
        elp_pkg::REG_TOLERANCE:    cfg_r.tolerance    <= cfg_data[11:0];
        elp_pkg::REG_MAX_SPEED:    cfg_r.max_speed    <= cfg_data[7:0];
        elp_pkg::REG_CM_PER_COUNT: cfg_r.cm_per_count <= cfg_data;
        elp_pkg::REG_FAST_FACTOR:  cfg_r.fast_factor  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/elp_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on elp_pkg for the operand widths.
`default_nettype none

module elp_mul (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [elp_pkg::MA_W-1:0]   a,
  input  wire logic signed [elp_pkg::MB_W-1:0]   b,
  output logic signed      [elp_pkg::PROD_W-1:0] prod_r
);

  // Register the product when the sequencer issues an operation
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/elp_fsm.sv =====
// Sequencer of the elevator position loop: steps one request through the
// shared multiplier and the datapath. Depends on elp_pkg for state_t and ctrl_t.
`default_nettype none

module elp_fsm (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [1:0] in_action,
  input  wire logic       out_free,
  output elp_pkg::ctrl_t  ctrl
);

  elp_pkg::state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= elp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through the steps of each action
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      elp_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            elp_pkg::ACT_TICK: state_nxt = elp_pkg::ST_TICK_MUL;
            elp_pkg::ACT_SET:  state_nxt = elp_pkg::ST_TARGET;
            elp_pkg::ACT_MOVE: state_nxt = elp_pkg::ST_FAST_MUL;
            default:           state_nxt = elp_pkg::ST_DONE;
          endcase
        end
      end
      elp_pkg::ST_TICK_MUL:  state_nxt = elp_pkg::ST_TICK_ACC;
      elp_pkg::ST_TICK_ACC:  state_nxt = elp_pkg::ST_ERR;
      elp_pkg::ST_ERR:       state_nxt = elp_pkg::ST_SPEED_MUL;
      elp_pkg::ST_SPEED_MUL: state_nxt = elp_pkg::ST_SPEED_ABS;
      elp_pkg::ST_SPEED_ABS: state_nxt = elp_pkg::ST_RECIP_MUL;
      elp_pkg::ST_RECIP_MUL: state_nxt = elp_pkg::ST_CORR_MUL;
      elp_pkg::ST_CORR_MUL:  state_nxt = elp_pkg::ST_DRIVE;
      elp_pkg::ST_DRIVE:     state_nxt = elp_pkg::ST_DONE;
      elp_pkg::ST_FAST_MUL:  state_nxt = elp_pkg::ST_TARGET;
      elp_pkg::ST_TARGET:    state_nxt = elp_pkg::ST_DONE;
      elp_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = elp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = elp_pkg::ST_IDLE;
    endcase
  end

  // Drive the datapath controls of each step
  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = elp_pkg::MUL_TICK;
    unique case (state_r)
      elp_pkg::ST_IDLE:      ctrl.in_ready = 1'b1;
      elp_pkg::ST_TICK_MUL: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = elp_pkg::MUL_TICK;
      end
      elp_pkg::ST_TICK_ACC:  ctrl.ld_acc = 1'b1;
      elp_pkg::ST_ERR:       ctrl.ld_err = 1'b1;
      elp_pkg::ST_SPEED_MUL: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = elp_pkg::MUL_SPEED;
      end
      elp_pkg::ST_SPEED_ABS: ctrl.ld_abs = 1'b1;
      elp_pkg::ST_RECIP_MUL: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = elp_pkg::MUL_RECIP;
      end
      elp_pkg::ST_CORR_MUL: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = elp_pkg::MUL_CORR;
        ctrl.ld_q0   = 1'b1;
      end
      elp_pkg::ST_DRIVE:     ctrl.ld_drive = 1'b1;
      elp_pkg::ST_FAST_MUL: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = elp_pkg::MUL_FAST;
      end
      elp_pkg::ST_TARGET:    ctrl.ld_target = 1'b1;
      elp_pkg::ST_DONE:      ctrl.ld_out = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/elevator_position_loop.sv =====
// Channel    | Dir | Handshake        | Payload
// in_ch      | in  | valid / ready    | action, encoder_count, top_switch, stop_button,
//            |     |                  | amount, fast_move
// out_ch     | out | valid / ready    | drive, height, on_target
// cfg_*      | in  | cfg_we, no wait  | cfg_index, cfg_data
//
// A control tick runs four operations on the one shared multiplier (odometry, speed,
// reciprocal of 700, remainder check), with add, clamp and compare steps around them.
// A target set runs only the target step, a relative move a fast-factor multiply
// first; an unused action goes straight to the final step. in_ch.ready is high only
// while the sequencer is idle. The result sits in an output register, so a new request
// is taken while it waits; a stalled out_ch holds the sequencer in its last step.
// Reset (rst_n low, synchronous) clears the loop state and loads the register defaults.
//
// Top level of the elevator position loop; depends on elp_pkg, elp_if,
// elp_cfg_regs, elp_mul and elp_fsm.
`default_nettype none

module elevator_position_loop (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  elp_in_if.sink                              in_ch,
  elp_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [elp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [elp_pkg::CFG_DATA_W-1:0] cfg_data
);

  elp_pkg::cfg_t  cfg;
  elp_pkg::ctrl_t ctrl;

  logic in_fire;
  logic out_free;

  // Request registers
  logic        [1:0]                 act_r;
  logic                              top_r;
  logic                              stop_r;
  logic                              fast_r;
  logic signed [elp_pkg::AMT_W-1:0]  amount_r;
  logic signed [elp_pkg::CNT_W:0]    delta_r;

  // Loop state
  logic signed [elp_pkg::CNT_W-1:0]  last_count_r;
  logic                              primed_r;
  logic signed [elp_pkg::ACC_W-1:0]  height_acc_r;
  logic signed [elp_pkg::AMT_W-1:0]  target_r;
  logic                              reached_r;
  logic signed [elp_pkg::DRV_W-1:0]  drive_r;

  // Intermediate results
  logic signed [elp_pkg::ERR_W-1:0]  err_r;
  logic        [elp_pkg::X_W-1:0]    x_r;
  logic                              neg_r;
  logic        [elp_pkg::Q_W-1:0]    q0_r;

  // Output register
  logic                              out_valid_r;
  logic signed [elp_pkg::DRV_W-1:0]  out_drive_r;
  logic signed [elp_pkg::HGT_W-1:0]  out_height_r;
  logic                              out_on_target_r;

  // Shared multiplier
  logic signed [elp_pkg::MA_W-1:0]   mul_a;
  logic signed [elp_pkg::MB_W-1:0]   mul_b;
  logic signed [elp_pkg::PROD_W-1:0] prod_r;
  logic        [elp_pkg::Q_W-1:0]    q0_w;

  // Step results
  logic signed [elp_pkg::CNT_W:0]    delta_nxt;
  logic signed [49:0]                acc_sum;
  logic signed [elp_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [elp_pkg::ACC_W:0]    err_raw;
  logic signed [elp_pkg::ACC_W:0]    err_hi;
  logic signed [elp_pkg::ERR_W-1:0]  err_nxt;
  logic signed [31:0]                p_w;
  logic        [31:0]                p_abs;
  logic        [27:0]                cap_w;
  logic        [27:0]                p_mag;
  logic        [27:0]                rem_w;
  logic        [elp_pkg::Q_W:0]      q_w;
  logic        [elp_pkg::DRV_W-1:0]  mag_w;
  logic signed [elp_pkg::DRV_W-1:0]  drv_w;
  logic        [elp_pkg::ERR_W-1:0]  err_abs;
  logic                              within_tol;
  logic signed [31:0]                base_w;
  logic signed [32:0]                cand_w;
  logic signed [32:0]                delta_t;
  logic signed [32:0]                low_w;
  logic signed [32:0]                high_w;
  logic signed [32:0]                t1_w;
  logic signed [32:0]                t2_w;
  logic signed [elp_pkg::HGT_W-1:0]  height_w;

  elp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  elp_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_action (in_ch.action),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  elp_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_ch.ready = ctrl.in_ready;
  assign in_fire     = in_ch.valid && ctrl.in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Count change since the last tick; zero on the first one
  assign delta_nxt = primed_r ?
                     ({in_ch.encoder_count[elp_pkg::CNT_W-1], in_ch.encoder_count} -
                      {last_count_r[elp_pkg::CNT_W-1], last_count_r}) : '0;

  // Latch the request and the encoder bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r    <= in_ch.action;
      top_r    <= in_ch.top_switch;
      stop_r   <= in_ch.stop_button;
      fast_r   <= in_ch.fast_move;
      amount_r <= in_ch.amount;
      delta_r  <= delta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      primed_r     <= 1'b0;
    end else if (in_fire && (in_ch.action == elp_pkg::ACT_TICK)) begin
      last_count_r <= in_ch.encoder_count;
      primed_r     <= 1'b1;
    end
  end

  // Select multiplier operands
  assign q0_w = prod_r[elp_pkg::RECIP_SHIFT+elp_pkg::Q_W-1:elp_pkg::RECIP_SHIFT];

  always_comb begin
    unique case (ctrl.mul_sel)
      elp_pkg::MUL_TICK: begin
        mul_a = delta_r;
        mul_b = $signed({13'b0, cfg.cm_per_count});
      end
      elp_pkg::MUL_SPEED: begin
        mul_a = {{(elp_pkg::MA_W-elp_pkg::ERR_W){err_r[elp_pkg::ERR_W-1]}}, err_r};
        mul_b = $signed({21'b0, cfg.max_speed});
      end
      elp_pkg::MUL_RECIP: begin
        mul_a = $signed({6'b0, x_r});
        mul_b = $signed({1'b0, elp_pkg::RECIP_700});
      end
      elp_pkg::MUL_CORR: begin
        mul_a = $signed({16'b0, q0_w});
        mul_b = $signed({18'b0, elp_pkg::DIV_700});
      end
      elp_pkg::MUL_FAST: begin
        mul_a = {{(elp_pkg::MA_W-elp_pkg::AMT_W){amount_r[elp_pkg::AMT_W-1]}}, amount_r};
        mul_b = $signed({17'b0, cfg.fast_factor});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Accumulate the height change with saturation; top switch overrides
  assign acc_sum = {{10{height_acc_r[elp_pkg::ACC_W-1]}}, height_acc_r} +
                   {prod_r[48], prod_r[48:0]};

  always_comb begin
    if (top_r) begin
      acc_nxt = $signed({16'b0, cfg.high_limit, 8'b0});
    end else if (acc_sum[49:39] == {11{acc_sum[39]}}) begin
      acc_nxt = acc_sum[39:0];
    end else if (acc_sum[49]) begin
      acc_nxt = {1'b1, {(elp_pkg::ACC_W-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(elp_pkg::ACC_W-1){1'b1}}};
    end
  end

  // Clamp the error to the proportional band
  assign err_raw = {{16{target_r[elp_pkg::AMT_W-1]}}, target_r, 8'b0} -
                   {height_acc_r[elp_pkg::ACC_W-1], height_acc_r};
  assign err_hi  = {{(elp_pkg::ACC_W+1-elp_pkg::ERR_W){1'b0}}, elp_pkg::ERR_CLAMP};

  always_comb begin
    if (err_raw > err_hi) begin
      err_nxt = elp_pkg::ERR_CLAMP;
    end else if (err_raw < -err_hi) begin
      err_nxt = -elp_pkg::ERR_CLAMP;
    end else begin
      err_nxt = err_raw[elp_pkg::ERR_W-1:0];
    end
  end

  // Cap the speed term, take its magnitude and add the rounding half
  assign p_w   = prod_r[31:0];
  assign p_abs = p_w[31] ? 32'(-p_w) : 32'(p_w);
  assign cap_w = {2'b0, cfg.max_speed, 18'b0} + {4'b0, cfg.max_speed, 16'b0};
  assign p_mag = (p_abs > {4'b0, cap_w}) ? cap_w : p_abs[27:0];

  // Correct the trial quotient by one where the remainder reaches 700
  assign rem_w = {1'b0, x_r} - {1'b0, prod_r[elp_pkg::X_W-1:0]};
  assign q_w   = {1'b0, q0_r} + {{elp_pkg::Q_W{1'b0}}, (rem_w >= 28'(elp_pkg::DIV_700))};
  assign mag_w = (q_w > {2'b0, elp_pkg::DRIVE_LIMIT}) ? elp_pkg::DRIVE_LIMIT :
                 q_w[elp_pkg::DRV_W-1:0];
  assign drv_w = neg_r ? -$signed(mag_w) : $signed(mag_w);

  assign err_abs    = err_r[elp_pkg::ERR_W-1] ? 23'(-err_r) : 23'(err_r);
  assign within_tol = err_abs < {3'b0, cfg.tolerance, 8'b0};

  // New target: absolute, or relative to the current height, then clamped
  assign base_w  = height_acc_r[elp_pkg::ACC_W-1:8];
  assign delta_t = fast_r ? {{11{prod_r[29]}}, prod_r[29:8]} :
                            {{16{amount_r[elp_pkg::AMT_W-1]}}, amount_r};
  assign cand_w  = (act_r == elp_pkg::ACT_SET) ?
                   {{16{amount_r[elp_pkg::AMT_W-1]}}, amount_r} :
                   ({base_w[31], base_w} + delta_t);
  assign low_w   = $signed({17'b0, cfg.low_limit});
  assign high_w  = $signed({17'b0, cfg.high_limit});
  assign t1_w    = (cand_w < low_w) ? low_w : cand_w;
  assign t2_w    = (t1_w > high_w) ? high_w : t1_w;

  // Loop state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_acc_r <= '0;
      target_r     <= '0;
      reached_r    <= 1'b0;
      drive_r      <= '0;
    end else begin
      if (ctrl.ld_acc) begin
        height_acc_r <= acc_nxt;
      end
      if (ctrl.ld_drive) begin
        drive_r <= (within_tol || stop_r) ? '0 : drv_w;
        if (within_tol) begin
          reached_r <= 1'b1;
        end
      end
      if (ctrl.ld_target) begin
        target_r  <= t2_w[elp_pkg::AMT_W-1:0];
        reached_r <= 1'b0;
      end
    end
  end

  // Intermediate registers between multiplier passes
  always_ff @(posedge clk) begin
    if (ctrl.ld_err) begin
      err_r <= err_nxt;
    end
    if (ctrl.ld_abs) begin
      x_r   <= elp_pkg::X_W'(p_mag + elp_pkg::ROUND_700);
      neg_r <= p_w[31];
    end
    if (ctrl.ld_q0) begin
      q0_r <= q0_w;
    end
  end

  // Saturate the reported height
  always_comb begin
    if (base_w[31:23] == {9{base_w[23]}}) begin
      height_w = base_w[elp_pkg::HGT_W-1:0];
    end else if (base_w[31]) begin
      height_w = {1'b1, {(elp_pkg::HGT_W-1){1'b0}}};
    end else begin
      height_w = {1'b0, {(elp_pkg::HGT_W-1){1'b1}}};
    end
  end

  // Output register: load the result, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      out_drive_r     <= drive_r;
      out_height_r    <= height_w;
      out_on_target_r <= reached_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive     = out_drive_r;
  assign out_ch.height    = out_height_r;
  assign out_ch.on_target = out_on_target_r;

endmodule

`default_nettype wire

// ===== hdl/elp_checker.sv =====
// Port-level checks of the elevator position loop, bound to the top level.
// Depends on elp_pkg for the drive limit and field widths.
`default_nettype none

module elp_props (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [elp_pkg::DRV_W-1:0] out_drive
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pend_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Count requests whose results are not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_fire && !out_fire) begin
      pend_r <= (pend_r == 2'd3) ? pend_r : pend_r + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend_r <= (pend_r == 2'd0) ? pend_r : pend_r - 2'd1;
    end
  end

  // A result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // The sequencer is busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("request taken while the previous one is in progress");

  // No result without an outstanding request
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> (pend_r != 2'd0))
    else $error("result without a request");

  // At most one request in work and one result waiting
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more requests outstanding than the block can hold");

  // Motor command stays within the power clamp
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_drive <= $signed({1'b0, elp_pkg::DRIVE_LIMIT[14:0]})) &&
                   (out_drive >= -$signed({1'b0, elp_pkg::DRIVE_LIMIT[14:0]}))))
    else $error("drive outside the power clamp");

endmodule

bind elevator_position_loop elp_props u_elp_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_drive (out_ch.drive)
);

`default_nettype wire
